[rtl/core/hse_pkg.sv]
// Shared types, constants and the code-length function for the Hamming
// section encoder. No dependencies.
package hse_pkg;

  localparam int MaxSectionBytes = 32;
  localparam int ByteW           = 8;
  localparam int LenW            = 6;
  localparam int PosW            = 9;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [PosW-1:0]  pos_t;

  // Control from the sequencer to the shared position cursor.
  typedef struct packed {
    logic init_fold;
    logic init_emit;
    logic step;
    logic emit_mode;
  } cur_ctl_t;

  // Code word length K + m for a section of len bytes (1..32), where m is
  // the smallest parity count with 2^m >= m + K + 1.
  function automatic pos_t code_total(input len_t len);
    pos_t k;
    pos_t m;
    k = {len, 3'b000};
    if (k <= pos_t'(11)) begin
      m = pos_t'(4);
    end else if (k <= pos_t'(26)) begin
      m = pos_t'(5);
    end else if (k <= pos_t'(57)) begin
      m = pos_t'(6);
    end else if (k <= pos_t'(120)) begin
      m = pos_t'(7);
    end else if (k <= pos_t'(247)) begin
      m = pos_t'(8);
    end else begin
      m = pos_t'(9);
    end
    return k + m;
  endfunction

endpackage

[rtl/core/hse_if.sv]
// Valid/ready channel interfaces for the Hamming section encoder.
// Depends on hse_pkg for the payload types.
interface hse_in_if import hse_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hse_out_if import hse_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t code_byte;
  logic  last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

interface hse_cfg_if import hse_pkg::*; ();
  logic valid;
  logic ready;
  len_t section_len;

  modport source (output valid, output section_len, input ready);
  modport sink (input valid, input section_len, output ready);
endinterface

[rtl/core/hse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/hse_cursor.sv]
// Shared code-position cursor: walks the data positions (skipping parity
// slots) while folding, and every position while emitting. Uses hse_pkg.
module hse_cursor import hse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cur_ctl_t ctl_i,
  output pos_t     pos_o,
  output logic     is_pow_o
);

  pos_t              pos_q, pos_d;
  logic [PosW:0]     np_q, np_d;
  pos_t              pos_inc;
  logic              is_pow;

  assign pos_inc = pos_q + pos_t'(1);
  assign is_pow  = ({1'b0, pos_q} == np_q);

  always_comb begin
    pos_d = pos_q;
    np_d  = np_q;
    if (ctl_i.init_fold) begin
      // Positions 1 and 2 hold parity; the first data bit sits at 3.
      pos_d = pos_t'(3);
      np_d  = (PosW+1)'(4);
    end else if (ctl_i.init_emit) begin
      pos_d = pos_t'(1);
      np_d  = (PosW+1)'(1);
    end else if (ctl_i.step) begin
      if (ctl_i.emit_mode) begin
        pos_d = pos_inc;
        if (is_pow) begin
          np_d = {np_q[PosW-1:0], 1'b0};
        end
      end else if ({1'b0, pos_inc} == np_q) begin
        // Powers of two beyond 2 are never adjacent, so one skip suffices.
        pos_d = pos_q + pos_t'(2);
        np_d  = {np_q[PosW-1:0], 1'b0};
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= pos_t'(3);
      np_q  <= (PosW+1)'(4);
    end else begin
      pos_q <= pos_d;
      np_q  <= np_d;
    end
  end

  assign pos_o    = pos_q;
  assign is_pow_o = is_pow;

endmodule

[rtl/core/hamming_section_encoder_unit.sv]
// Top level of the Hamming section encoder: sequencer, section store and
// output register. Uses hse_pkg, hse_if, hse_ram and hse_cursor.
//
//   channel  dir  payload                 transfer when
//   cfg_i    in   section_len [5:0]       valid && ready (ready always high)
//   in_i     in   data_byte [7:0]         valid && ready (ready low while cfg_i.valid)
//   out_o    out  code_byte [7:0], last   valid && ready
//
// Each data byte is stored in S_IDLE, then its eight bits are folded into
// the parity through the shared position cursor, one bit per cycle.
// After the last byte of a section the code word is built one position per
// cycle while the output is not stalled (K + m positions plus padding), with
// S_FETCH and S_LOAD per data byte to read it back from the store; in_i is not
// ready until the last code byte sits in the output register. Reset leaves section_len at 1.
// A stalled output holds the sequencer only when a new byte is complete.
module hamming_section_encoder_unit import hse_pkg::*; #(
  parameter int MAX_SECTION_BYTES = MaxSectionBytes
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  hse_cfg_if.sink cfg_i,
  hse_in_if.sink  in_i,
  hse_out_if.source out_o
);

  localparam int   AddrW  = (MAX_SECTION_BYTES > 1) ? $clog2(MAX_SECTION_BYTES) : 1;
  localparam len_t MaxLen = len_t'(MAX_SECTION_BYTES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FOLD  = 5'b00010,
    S_FETCH = 5'b00100,
    S_LOAD  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  len_t        len_q, len_d;
  len_t        rcv_q, rcv_d;
  logic [8:0]  par_q, par_d;
  byte_t       sh_q, sh_d;
  logic [2:0]  bcnt_q, bcnt_d;
  logic [3:0]  j_q, j_d;
  pos_t        d_q, d_d;
  logic        dvalid_q, dvalid_d;
  byte_t       ob_q, ob_d;
  logic [2:0]  obc_q, obc_d;
  pos_t        total_q, total_d;
  logic        out_valid_q, out_valid_d;
  byte_t       code_q, code_d;
  logic        last_q, last_d;

  len_t        eff_len;
  len_t        rcv_inc;
  cur_ctl_t    cur_ctl;
  pos_t        pos;
  logic        is_pow;
  logic        past_end;
  logic        bit_val;
  logic        ram_we;
  logic        ram_re;
  byte_t       ram_rdata;
  logic        in_xfer;
  logic        cfg_xfer;

  assign eff_len  = (len_q == '0) ? len_t'(1) : ((len_q > MaxLen) ? MaxLen : len_q);
  assign rcv_inc  = rcv_q + len_t'(1);
  assign past_end = (pos > total_q);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;
  assign ram_we   = in_xfer;
  assign ram_re   = (state_q == S_FETCH);

  hse_ram #(
    .WIDTH (ByteW),
    .DEPTH (MAX_SECTION_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rcv_q[AddrW-1:0]),
    .wdata_i (in_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (d_q[AddrW+2:3]),
    .rdata_o (ram_rdata)
  );

  hse_cursor u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (cur_ctl),
    .pos_o    (pos),
    .is_pow_o (is_pow)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rcv_d       = rcv_q;
    par_d       = par_q;
    sh_d        = sh_q;
    bcnt_d      = bcnt_q;
    j_d         = j_q;
    d_d         = d_q;
    dvalid_d    = dvalid_q;
    ob_d        = ob_q;
    obc_d       = obc_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_o.ready;
    code_d      = code_q;
    last_d      = last_q;
    cur_ctl     = '0;
    cur_ctl.emit_mode = (state_q == S_EMIT);
    bit_val     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          sh_d    = in_i.data_byte;
          bcnt_d  = '0;
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        if (sh_q[7]) begin
          par_d = par_q ^ pos;
        end
        sh_d         = {sh_q[6:0], 1'b0};
        bcnt_d       = bcnt_q + 3'd1;
        cur_ctl.step = 1'b1;
        if (bcnt_q == 3'd7) begin
          if (rcv_inc >= eff_len) begin
            rcv_d            = '0;
            total_d          = code_total(eff_len);
            cur_ctl.init_emit = 1'b1;
            j_d              = '0;
            d_d              = '0;
            dvalid_d         = 1'b0;
            obc_d            = '0;
            state_d          = S_EMIT;
          end else begin
            rcv_d   = rcv_inc;
            state_d = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        sh_d     = ram_rdata;
        dvalid_d = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!past_end && !is_pow && !dvalid_q) begin
          state_d = S_FETCH;
        end else if (!(obc_q == 3'd7 && out_valid_q && !out_o.ready)) begin
          if (past_end) begin
            bit_val = 1'b0;
          end else if (is_pow) begin
            bit_val = par_q[j_q];
            j_d     = j_q + 4'd1;
          end else begin
            bit_val = sh_q[7];
            sh_d    = {sh_q[6:0], 1'b0};
            d_d     = d_q + pos_t'(1);
            if (d_q[2:0] == 3'd7) begin
              dvalid_d = 1'b0;
            end
          end
          cur_ctl.step = 1'b1;
          ob_d         = {ob_q[6:0], bit_val};
          obc_d        = obc_q + 3'd1;
          if (obc_q == 3'd7) begin
            out_valid_d = 1'b1;
            code_d      = {ob_q[6:0], bit_val};
            last_d      = (pos >= total_q);
            if (pos >= total_q) begin
              par_d             = '0;
              cur_ctl.init_fold = 1'b1;
              state_d           = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A length write abandons any partial section.
    if (cfg_xfer) begin
      len_d             = cfg_i.section_len;
      rcv_d             = '0;
      par_d             = '0;
      cur_ctl.init_fold = 1'b1;
      state_d           = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= len_t'(1);
      rcv_q       <= '0;
      par_q       <= '0;
      bcnt_q      <= '0;
      j_q         <= '0;
      d_q         <= '0;
      dvalid_q    <= 1'b0;
      obc_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rcv_q       <= rcv_d;
      par_q       <= par_d;
      bcnt_q      <= bcnt_d;
      j_q         <= j_d;
      d_q         <= d_d;
      dvalid_q    <= dvalid_d;
      obc_q       <= obc_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    ob_q   <= ob_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  // A pending length write takes the cycle, so no data byte lands in it.
  assign cfg_i.ready     = 1'b1;
  assign in_i.ready      = (state_q == S_IDLE) && !cfg_i.valid;
  assign out_o.valid     = out_valid_q;
  assign out_o.code_byte = code_q;
  assign out_o.last_byte = last_q;

endmodule

[tb/sv/hse_code_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the Hamming section encoder: watches the length, data and code
// channels, predicts each code word and compares it byte by byte.
// Depends on hse_pkg and the channel interfaces in hse_if.
module hse_code_checker import hse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  hse_cfg_if   cfg_i,
  hse_in_if    in_i,
  hse_out_if   out_i,
  output int   err_count_o,
  output int   pending_o,
  output int   results_o,
  output int   sections_o
);

  localparam int CodeBytesMax = MaxSectionBytes + 2;

  typedef struct packed {
    byte_t code_byte;
    logic  last_byte;
  } code_beat_t;

  code_beat_t expected_code_q[$];
  byte_t      section_bytes [MaxSectionBytes];
  int         eff_len;
  int         fill;
  int         errors;
  int         results;
  int         sections;

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int         k_bits;
    int         m_bits;
    int         total;
    int         n_bytes;
    int         d;
    int         ppos;
    pos_t       parity;
    logic       b;
    byte_t      word [CodeBytesMax];
    code_beat_t want;
    len_t       raw;
    if (!rst_ni) begin
      eff_len = 1;
      fill = 0;
      errors = 0;
      results = 0;
      sections = 0;
      expected_code_q.delete();
      err_count_o <= 0;
      pending_o <= 0;
      results_o <= 0;
      sections_o <= 0;
    end else begin
      // Any length write drops a partly collected section.
      if (cfg_i.valid && cfg_i.ready) begin
        raw = cfg_i.section_len;
        if (raw == '0) begin
          eff_len = 1;
        end else if (int'(raw) > MaxSectionBytes) begin
          eff_len = MaxSectionBytes;
        end else begin
          eff_len = int'(raw);
        end
        fill = 0;
      end

      if (out_i.valid && out_i.ready) begin
        results++;
        if (expected_code_q.size() == 0) begin
          $error("code byte %h (last %b) arrived with no code word pending",
                 out_i.code_byte, out_i.last_byte);
          errors++;
        end else begin
          want = expected_code_q.pop_front();
          if (out_i.code_byte !== want.code_byte) begin
            $error("code_byte: expected %h, got %h", want.code_byte, out_i.code_byte);
            errors++;
          end
          if (out_i.last_byte !== want.last_byte) begin
            $error("last_byte: expected %b, got %b", want.last_byte, out_i.last_byte);
            errors++;
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        section_bytes[fill] = in_i.data_byte;
        fill++;
        if (fill >= eff_len) begin
          k_bits = eff_len * 8;
          m_bits = 0;
          while ((1 << m_bits) < m_bits + k_bits + 1) m_bits++;
          total = k_bits + m_bits;
          n_bytes = (total + 7) / 8;
          for (int i = 0; i < CodeBytesMax; i++) word[i] = '0;
          // Data bits fill the non power-of-two positions; each set bit folds its
          // position into the parity syndrome.
          parity = '0;
          d = 0;
          for (int p = 1; p <= total; p++) begin
            if ((p & (p - 1)) != 0) begin
              b = section_bytes[d / 8][7 - (d % 8)];
              d++;
              if (b) parity ^= pos_t'(p);
              word[(p - 1) / 8][7 - ((p - 1) % 8)] = b;
            end
          end
          for (int j = 0; (1 << j) <= total; j++) begin
            ppos = (1 << j) - 1;
            word[ppos / 8][7 - (ppos % 8)] = parity[j];
          end
          for (int i = 0; i < n_bytes; i++) begin
            want.code_byte = word[i];
            want.last_byte = (i == n_bytes - 1);
            expected_code_q.insert(expected_code_q.size(), want);
          end
          fill = 0;
          sections++;
        end
      end

      err_count_o <= errors;
      pending_o <= expected_code_q.size();
      results_o <= results;
      sections_o <= sections;
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for hamming_section_encoder_unit: clock, reset, stimulus,
// back-pressure and verdict. Needs hse_pkg, hse_if and hse_code_checker.
module tb_top;
  import hse_pkg::*;

  localparam int SettleCycles  = 24;
  localparam int HoldOffCycles = 300;
  localparam int CycleLimit    = 400000;
  localparam int RandomItems   = 230;

  logic clk;
  logic rst_n;
  logic send_idle    = 1'b0;
  logic recv_idle    = 1'b0;
  logic hold_off_req = 1'b0;
  int   items_sent   = 0;
  int   cfg_writes   = 0;
  int   directed     = 0;
  int   cycle_count;
  int   err_count;
  int   pending;
  int   results_seen;
  int   sections_seen;

  hse_cfg_if cfg_if ();
  hse_in_if  in_if ();
  hse_out_if out_if ();

  hamming_section_encoder_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  hse_code_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_i      (cfg_if),
    .in_i       (in_if),
    .out_i      (out_if),
    .err_count_o(err_count),
    .pending_o  (pending),
    .results_o  (results_seen),
    .sections_o (sections_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input byte_t value);
    int gap;
    gap = (send_idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      in_if.data_byte <= byte_t'($urandom_range(0, 255));
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data_byte <= value;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic write_len(input len_t raw);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.section_len <= raw;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Wait for every predicted code byte, then let a byte still being folded finish.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic run_sections(input len_t raw, input int count, input int extra);
    int eff;
    eff = (raw == '0) ? 1 : ((int'(raw) > MaxSectionBytes) ? MaxSectionBytes : int'(raw));
    settle();
    write_len(raw);
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
    repeat (count * eff + extra) send_byte(byte_t'($urandom_range(0, 255)));
  endtask

  initial begin : result_sink
    int gap;
    int hold_left;
    gap = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left == 0 && gap == 0 && recv_idle && $urandom_range(0, 3) == 0) begin
        gap = gap_len();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d code bytes outstanding.", cycle_count, pending);
    $display("** hamming_section_encoder_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int kind;
    int raw;
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.section_len = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset length of one byte, with all-zero, all-one and single-bit data.
    recv_idle = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    // A zero length behaves as one byte.
    settle();
    write_len(len_t'(0));
    send_byte(8'hA5);
    send_byte(8'h5A);
    // Oversized length saturates; the partial section is dropped by the next write.
    settle();
    write_len(len_t'(63));
    send_byte(8'hF0);
    send_byte(8'h0F);
    send_byte(8'hC3);
    settle();
    write_len(len_t'(2));
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    settle();
    write_len(len_t'(3));
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h81);
    directed = items_sent;

    // Long output stall while one-byte sections keep coming, so the input backs up.
    settle();
    write_len(len_t'(1));
    send_idle = 1'b0;
    hold_off_req = 1'b1;
    repeat (12) send_byte(byte_t'($urandom_range(0, 255)));

    run_sections(len_t'(63), 1, 0);
    run_sections(len_t'(31), 1, 0);
    while (items_sent - directed < RandomItems) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        case ($urandom_range(0, 3))
          0: raw = 31;
          1: raw = 32;
          2: raw = $urandom_range(33, 63);
          default: raw = $urandom_range(20, 30);
        endcase
        run_sections(len_t'(raw), 1, 0);
      end else if (kind == 1) begin
        raw = $urandom_range(2, 8);
        run_sections(len_t'(raw), $urandom_range(0, 2), $urandom_range(1, raw - 1));
      end else begin
        raw = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        run_sections(len_t'(raw), $urandom_range(1, 4), 0);
      end
    end

    settle();
    repeat (SettleCycles) @(negedge clk);
    $display("Sent %0d data bytes (%0d directed) over %0d length writes; %0d sections done.",
             items_sent, directed, cfg_writes, sections_seen);
    $display("Checked %0d code bytes across zero, saturated and abandoned lengths.",
             results_seen);
    if (err_count == 0 && pending == 0) begin
      $display("** hamming_section_encoder_unit: PASSED **");
    end else begin
      $display("** hamming_section_encoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
